// File: hw/rtl/ppu_pkg.sv
// Shared types, codes and constant tables of the polychromatic projection unit.
package ppu_pkg;

   localparam int FRAC_BITS = 24;

   localparam logic [6:0]  EXP_SCALE = 7'd100;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [31:0] LN2_Q32   = 32'hB17217F8;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_PIXEL = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_NUM_ENERGIES  = 2'd0,
      REG_NUM_MATERIALS = 2'd1,
      REG_REFERENCE     = 2'd2
   } reg_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_FETCH,
      S_MAT,
      S_SCALE,
      S_EXPCHK,
      S_ROOT,
      S_PHI,
      S_PLO,
      S_SHIFT,
      S_ACC,
      S_CHECK,
      S_NORM,
      S_SQ,
      S_DIFF,
      S_LN2,
      S_ROUND,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic        operation;
      logic [7:0]  entry_index;
      logic [7:0]  energy_kev;
      logic [31:0] photon_weight;
      logic [31:0] material_value_0;
      logic [31:0] material_value_1;
      logic [31:0] material_value_2;
      logic [31:0] material_value_3;
      logic        pixel_last;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] attenuation;
      logic               image_last;
      logic               saturated;
   } rsp_word_type;

   // Root j is about 2^31 * 2^(-2^-(j+1)), Q0.31.
   typedef logic [FRAC_BITS-1:0][30:0] root_table_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] rem;
      logic [63:0] r;
      logic [63:0] b;
      rem = x;
      r   = 64'd0;
      b   = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r   = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic root_table_type build_roots();
      root_table_type t;
      logic [63:0]    prev;
      prev = isqrt64(64'd1 << 61);
      t[0] = prev[30:0];
      for (int j = 1; j < FRAC_BITS; j++) begin
         prev = isqrt64(prev << 31);
         t[j] = prev[30:0];
      end
      return t;
   endfunction

endpackage

// File: hw/rtl/polychromatic_projection_unit.sv
// Polychromatic Beer-Lambert projection: spectrum memories, entry sequencer and log unit.
//
// Use: the req channel carries two kinds of word. A load word (operation 0) writes
// spectrum entry entry_index (energy, photon weight, one coefficient per material);
// it gives no result. A pixel word (operation 1) carries one
// projection per material and gives exactly one rsp word: attenuation, signed Q8.24,
// equal to -ln(sum / reference_intensity), with image_last copied from pixel_last.
// The csr port (APB style, 64-bit data, registers at 8*i) sets num_energies,
// num_materials and reference_intensity; write it only while the block is idle.
// Sequencing: the block works on one word at a time. A pixel walks its spectrum
// entries one after another through a single multiplier sequence: per entry one
// step per material and, unless the exponent overflows, the 24 steps of the
// fractional-power loop; then come the two 30-step logarithms and the final
// scaling.
// Reset: synchronous, active high; returns to idle, rsp_valid low, registers to
// num_energies 1, num_materials 1, reference_intensity 65536. Spectrum memories are not cleared;
// every entry read by a pixel must be loaded first.
// Stall: a finished result waits in the rsp register; the next word is accepted
// meanwhile, and a second pixel holds its result until the register frees up.
module polychromatic_projection_unit #(
   parameter int MAX_ENERGIES  = 256,
   parameter int MAX_MATERIALS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ppu_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ppu_pkg::rsp_word_type rsp_word,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [63:0]           csr_pwdata,
   output logic [63:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = (MAX_ENERGIES > 1) ? $clog2(MAX_ENERGIES) : 1;
   localparam int CW = $clog2(MAX_ENERGIES + 1);
   localparam ppu_pkg::root_table_type ROOTS = ppu_pkg::build_roots();

   // ---------------------------------------------------------------- registers
   logic [8:0]  num_energies_ff;
   logic [2:0]  num_materials_ff;
   logic [39:0] reference_ff;

   ppu_pkg::state_type state_ff, state_in;
   logic [CW-1:0] k_ff, k_in, ne_ff, ne_in;
   logic [2:0]    nm_ff, nm_in, mat_ff, mat_in;
   logic [4:0]    step_ff, step_in;
   logic [MAX_MATERIALS-1:0][31:0] proj_ff, proj_in;
   logic          last_ff, last_in;
   logic [41:0]   a_ff, a_in;
   logic [48:0]   a100_ff, a100_in;
   logic [39:0]   ew_ff, ew_in;
   logic [6:0]    n_ff, n_in;
   logic [23:0]   f_ff, f_in;
   logic [31:0]   m_ff, m_in;
   logic [51:0]   phi_ff, phi_in, plo_ff, plo_in;
   logic [63:0]   term_ff, term_in, acc_ff, acc_in;
   logic [63:0]   x_ff, x_in;
   logic [5:0]    msb_ff, msb_in;
   logic [31:0]   z_ff, z_in;
   logic [23:0]   frac_ff, frac_in;
   logic          sel_ff, sel_in;
   logic [30:0]   lr_ff, lr_in, la_ff, la_in, mag_ff, mag_in;
   logic          neg_ff, neg_in;
   logic [62:0]   lnp_ff, lnp_in;
   logic [31:0]   res_ff, res_in;
   logic          sat_ff, sat_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ppu_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // ---------------------------------------------------------------- memories
   // Entry row: energy above weight; coefficients one row per entry.
   logic [39:0] spec_mem [MAX_ENERGIES];
   logic [MAX_MATERIALS-1:0][31:0] coef_mem [MAX_ENERGIES];
   logic [39:0] spec_rd_ff;
   logic [MAX_MATERIALS-1:0][31:0] coef_rd_ff;
   logic        spec_we, spec_re;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [MAX_MATERIALS-1:0][31:0] load_row;

   logic [3:0][31:0] in_vals;
   logic [15:0] idx_wide;
   logic        req_accept;

   assign req_ready  = (state_ff == ppu_pkg::S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign in_vals    = {req_word.material_value_3, req_word.material_value_2,
                        req_word.material_value_1, req_word.material_value_0};
   assign idx_wide   = 16'(req_word.entry_index);
   assign wr_addr    = idx_wide[AW-1:0];
   assign rd_addr    = k_ff[AW-1:0];

   always_comb begin
      for (int i = 0; i < MAX_MATERIALS; i++) begin
         load_row[i] = in_vals[i];
      end
   end

   // Load words beyond the memory depth are dropped.
   assign spec_we = req_accept && (req_word.operation == ppu_pkg::OP_LOAD)
                    && (idx_wide < 16'(MAX_ENERGIES));
   assign spec_re = (state_ff == ppu_pkg::S_FETCH);

   always_ff @(posedge clock) begin
      if (spec_we) begin
         spec_mem[wr_addr] <= {req_word.energy_kev, req_word.photon_weight};
         coef_mem[wr_addr] <= load_row;
      end
      if (spec_re) begin
         spec_rd_ff <= spec_mem[rd_addr];
         coef_rd_ff <= coef_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------- csr port
   logic csr_write;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_energies_ff  <= 9'd1;
         num_materials_ff <= 3'd1;
         reference_ff     <= 40'd65536;
      end else if (csr_write) begin
         unique case (ppu_pkg::reg_index_type'(csr_paddr[4:3]))
            ppu_pkg::REG_NUM_ENERGIES:  num_energies_ff  <= csr_pwdata[8:0];
            ppu_pkg::REG_NUM_MATERIALS: num_materials_ff <= csr_pwdata[2:0];
            ppu_pkg::REG_REFERENCE:     reference_ff     <= csr_pwdata[39:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ppu_pkg::reg_index_type'(csr_paddr[4:3]))
         ppu_pkg::REG_NUM_ENERGIES:  csr_prdata = 64'(num_energies_ff);
         ppu_pkg::REG_NUM_MATERIALS: csr_prdata = 64'(num_materials_ff);
         ppu_pkg::REG_REFERENCE:     csr_prdata = 64'(reference_ff);
         default:                    csr_prdata = 64'd0;
      endcase
   end

   // ---------------------------------------------------------------- sequencer
   logic [15:0]  ne_full;
   logic [31:0]  coef_sel, proj_sel;
   logic [63:0]  mprod;
   logic [60:0]  yprod;
   logic [62:0]  rprod;
   logic [71:0]  full;
   logic [7:0]   shamt;
   logic [64:0]  acc_sum;
   logic [5:0]   sh;
   logic [63:0]  zz;
   logic [32:0]  q;
   logic [30:0]  l_val;
   logic [63:0]  rr;
   logic [31:0]  rnd;

   always_comb begin
      ne_full = (16'(num_energies_ff) > 16'(MAX_ENERGIES)) ? 16'(MAX_ENERGIES)
                                                            : 16'(num_energies_ff);
      coef_sel = 32'd0;
      proj_sel = 32'd0;
      for (int i = 0; i < MAX_MATERIALS; i++) begin
         if (mat_ff == 3'(i)) begin
            coef_sel = coef_rd_ff[i];
            proj_sel = proj_ff[i];
         end
      end
      mprod   = 64'(coef_sel) * 64'(proj_sel);
      yprod   = 61'(a100_ff[29:0]) * 61'(ppu_pkg::LOG2E_Q30);
      rprod   = 63'(m_ff) * 63'(ROOTS[step_ff]);
      full    = {phi_ff, 20'd0} + 72'(plo_ff);
      shamt   = 8'(n_ff) + 8'd15;
      acc_sum = {1'b0, acc_ff} + {1'b0, term_ff};
      sh      = 6'd32 >> step_ff;
      zz      = 64'(z_ff) * 64'(z_ff);
      q       = zz[63:31];
      l_val   = {1'b0, msb_ff, frac_ff[22:0], q[32]};
      rr      = 64'(lnp_ff) + 64'h8000_0000;
      rnd     = rr[63:32];

      state_in = state_ff;
      k_in = k_ff;  ne_in = ne_ff;  nm_in = nm_ff;  mat_in = mat_ff;  step_in = step_ff;
      proj_in = proj_ff;  last_in = last_ff;
      a_in = a_ff;  a100_in = a100_ff;  ew_in = ew_ff;  n_in = n_ff;  f_in = f_ff;
      m_in = m_ff;  phi_in = phi_ff;  plo_in = plo_ff;  term_in = term_ff;
      acc_in = acc_ff;  x_in = x_ff;  msb_in = msb_ff;  z_in = z_ff;  frac_in = frac_ff;
      sel_in = sel_ff;  lr_in = lr_ff;  la_in = la_ff;  mag_in = mag_ff;
      neg_in = neg_ff;  lnp_in = lnp_ff;  res_in = res_ff;  sat_in = sat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;

      // Free the result register as soon as the receiver takes it.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ppu_pkg::S_IDLE: begin
            if (req_accept && (req_word.operation == ppu_pkg::OP_PIXEL)) begin
               ne_in = ne_full[CW-1:0];
               nm_in = (num_materials_ff > 3'(MAX_MATERIALS)) ? 3'(MAX_MATERIALS)
                                                               : num_materials_ff;
               for (int i = 0; i < MAX_MATERIALS; i++) begin
                  proj_in[i] = in_vals[i];
               end
               last_in  = req_word.pixel_last;
               acc_in   = 64'd0;
               sat_in   = 1'b0;
               k_in     = '0;
               state_in = (ne_full == 16'd0) ? ppu_pkg::S_CHECK : ppu_pkg::S_FETCH;
            end
         end
         ppu_pkg::S_FETCH: begin
            a_in     = 42'd0;
            mat_in   = 3'd0;
            state_in = (nm_ff == 3'd0) ? ppu_pkg::S_SCALE : ppu_pkg::S_MAT;
         end
         ppu_pkg::S_MAT: begin
            a_in   = a_ff + 42'(mprod[63:24]);
            mat_in = mat_ff + 3'd1;
            if (mat_ff + 3'd1 == nm_ff) begin
               state_in = ppu_pkg::S_SCALE;
            end
         end
         ppu_pkg::S_SCALE: begin
            a100_in  = 49'(a_ff) * 49'(ppu_pkg::EXP_SCALE);
            ew_in    = 40'(spec_rd_ff[39:32]) * 40'(spec_rd_ff[31:0]);
            state_in = ppu_pkg::S_EXPCHK;
         end
         ppu_pkg::S_EXPCHK: begin
            // Exponent of 64 or more contributes nothing.
            if (|a100_ff[48:30]) begin
               term_in  = 64'd0;
               state_in = ppu_pkg::S_ACC;
            end else begin
               n_in     = yprod[60:54];
               f_in     = yprod[53:30];
               m_in     = 32'h8000_0000;
               step_in  = 5'd0;
               state_in = ppu_pkg::S_ROOT;
            end
         end
         ppu_pkg::S_ROOT: begin
            if (f_ff[23]) begin
               m_in = rprod[62:31];
            end
            f_in    = {f_ff[22:0], 1'b0};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(ppu_pkg::FRAC_BITS - 1)) begin
               state_in = ppu_pkg::S_PHI;
            end
         end
         ppu_pkg::S_PHI: begin
            phi_in   = 52'(ew_ff[39:20]) * 52'(m_ff);
            state_in = ppu_pkg::S_PLO;
         end
         ppu_pkg::S_PLO: begin
            plo_in   = 52'(ew_ff[19:0]) * 52'(m_ff);
            state_in = ppu_pkg::S_SHIFT;
         end
         ppu_pkg::S_SHIFT: begin
            term_in  = 64'(full >> shamt);
            state_in = ppu_pkg::S_ACC;
         end
         ppu_pkg::S_ACC: begin
            acc_in = acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0];
            k_in   = k_ff + 1'b1;
            state_in = (k_ff + 1'b1 == ne_ff) ? ppu_pkg::S_CHECK : ppu_pkg::S_FETCH;
         end
         ppu_pkg::S_CHECK: begin
            if (acc_ff == 64'd0) begin
               res_in   = 32'h7FFF_FFFF;
               sat_in   = 1'b1;
               state_in = ppu_pkg::S_EMIT;
            end else if (reference_ff == 40'd0) begin
               res_in   = 32'h8000_0000;
               sat_in   = 1'b1;
               state_in = ppu_pkg::S_EMIT;
            end else begin
               x_in     = 64'(reference_ff);
               msb_in   = 6'd63;
               sel_in   = 1'b0;
               step_in  = 5'd0;
               state_in = ppu_pkg::S_NORM;
            end
         end
         ppu_pkg::S_NORM: begin
            // Binary search for the top set bit: shift by 32, 16, ... 1.
            if ((x_ff >> (7'd64 - {1'b0, sh})) == 64'd0) begin
               x_in   = x_ff << sh;
               msb_in = msb_ff - sh;
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd5) begin
               step_in  = 5'd0;
               state_in = ppu_pkg::S_SQ;
            end
         end
         ppu_pkg::S_SQ: begin
            z_in    = q[32] ? q[32:1] : q[31:0];
            frac_in = {frac_ff[22:0], q[32]};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(ppu_pkg::FRAC_BITS - 1)) begin
               step_in = 5'd0;
               if (!sel_ff) begin
                  lr_in    = l_val + (31'd16 << ppu_pkg::FRAC_BITS);
                  x_in     = acc_ff;
                  msb_in   = 6'd63;
                  sel_in   = 1'b1;
                  state_in = ppu_pkg::S_NORM;
               end else begin
                  la_in    = l_val;
                  state_in = ppu_pkg::S_DIFF;
               end
            end
         end
         ppu_pkg::S_DIFF: begin
            neg_in   = la_ff > lr_ff;
            mag_in   = (la_ff > lr_ff) ? la_ff - lr_ff : lr_ff - la_ff;
            state_in = ppu_pkg::S_LN2;
         end
         ppu_pkg::S_LN2: begin
            lnp_in   = 63'(mag_ff) * 63'(ppu_pkg::LN2_Q32);
            state_in = ppu_pkg::S_ROUND;
         end
         ppu_pkg::S_ROUND: begin
            if (!neg_ff) begin
               if (rnd > 32'h7FFF_FFFF) begin
                  res_in = 32'h7FFF_FFFF;
                  sat_in = 1'b1;
               end else begin
                  res_in = rnd;
               end
            end else begin
               if (rnd > 32'h8000_0000) begin
                  res_in = 32'h8000_0000;
                  sat_in = 1'b1;
               end else begin
                  res_in = 32'd0 - rnd;
               end
            end
            state_in = ppu_pkg::S_EMIT;
         end
         ppu_pkg::S_EMIT: begin
            // Hold until the result register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.attenuation = res_ff;
               rsp_word_in.image_last  = last_ff;
               rsp_word_in.saturated   = sat_ff;
               state_in                = ppu_pkg::S_IDLE;
            end
         end
         default: state_in = ppu_pkg::S_IDLE;
      endcase

      // Seed the squaring loop with the normalized top word.
      if (state_ff == ppu_pkg::S_NORM && step_ff == 5'd5) begin
         z_in    = x_in[63:32];
         frac_in = 24'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppu_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         step_ff      <= 5'd0;
         mat_ff       <= 3'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         step_ff      <= step_in;
         mat_ff       <= mat_in;
      end
   end

   always_ff @(posedge clock) begin
      ne_ff <= ne_in;  nm_ff <= nm_in;  proj_ff <= proj_in;  last_ff <= last_in;
      a_ff <= a_in;  a100_ff <= a100_in;  ew_ff <= ew_in;  n_ff <= n_in;  f_ff <= f_in;
      m_ff <= m_in;  phi_ff <= phi_in;  plo_ff <= plo_in;  term_ff <= term_in;
      acc_ff <= acc_in;  x_ff <= x_in;  msb_ff <= msb_in;  z_ff <= z_in;
      frac_ff <= frac_in;  sel_ff <= sel_in;  lr_ff <= lr_in;  la_ff <= la_in;
      mag_ff <= mag_in;  neg_ff <= neg_in;  lnp_ff <= lnp_in;  res_ff <= res_in;
      sat_ff <= sat_in;  rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------------------------------------------------------- checks
   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.saturated |->
         (rsp_word.attenuation == 32'sh7FFF_FFFF) ||
         (rsp_word.attenuation == 32'sh8000_0000))
      else $error("saturated result not at a clip value");

   a_busy_after_pixel: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_word.operation == ppu_pkg::OP_PIXEL) |=> !req_ready)
      else $error("input taken while a pixel is in flight");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(spec_we && spec_re))
      else $error("spectrum memory written during a pixel read");

   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ppu_pkg::S_ROOT) |-> (step_ff < 5'(ppu_pkg::FRAC_BITS)))
      else $error("root step counter out of range");

endmodule
